// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the entropy health test RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check that cons holds in the same cycle whenever ante holds.
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Check that cons holds in the cycle after ante holds.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rstn, ante, cons)
`define ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

// ----- rtl/ehtu_pkg.sv -----
// Shared types and constants for the entropy health test unit.
`default_nettype none

package ehtu_pkg;

    localparam int SAMPLE_W     = 8;
    localparam int REP_CUT_W    = 8;
    localparam int PROP_CUT_W   = 13;
    localparam int WIN_SIZE_W   = 13;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_ADDR_W   = 2;
    localparam int OUT_COUNT_W  = 48;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_RUN_LIMIT   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_PROP_CUTOFF = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_SIZE = 2'd2;

    // Configuration reset values
    localparam logic [REP_CUT_W-1:0]  RUN_LIMIT_RST   = 8'd6;
    localparam logic [PROP_CUT_W-1:0] PROP_CUTOFF_RST = 13'd100;
    localparam logic [WIN_SIZE_W-1:0] WINDOW_SIZE_RST = 13'd1024;

    // Run length saturates here
    localparam logic [SAMPLE_W-1:0] RUN_MAX = 8'hFF;

    // Per-sample test outcome
    typedef struct packed {
        logic rep_fail;
        logic prop_fail;
    } flags_t;

endpackage

`default_nettype wire

// ----- rtl/entropy_health_tests_unit.sv -----
// Top level of the entropy health test unit: channels, config and result register.
//
// Usage:
//   Input channel (s_valid/s_ready) carries one 8-bit noise sample and a
//   block_end marker per transaction. Result channel (m_valid/m_ready)
//   returns one transaction per sample: repetition and proportion failure
//   flags, the sticky block failure flag, a copy of block_end and four
//   saturating statistics counts taken after this sample's update.
//   The sample is held in an input register and processed in one pass into
//   the result register, which raises m_valid once the result slot is free.
//   Throughput is one sample per cycle while m_ready stays high, set by the
//   combinational compare and increment path between the two registers.
//   When the receiver stalls, the result register holds and one more sample
//   waits in the input register; s_ready then drops until m_ready returns.
//   Reset (aresetn low, synchronous) empties both registers, clears all test
//   state and counters and loads the cutoffs to 6 and 100 and the window to
//   1024. Configuration (cfg_wr_en, cfg_addr, cfg_wdata) must be written only
//   while no transaction is in flight (not enforced); index 3 is ignored.
`default_nettype none
`include "assert_macros.svh"

module entropy_health_tests_unit #(
    parameter int MAX_WINDOW = 4096,
    parameter int STAT_WIDTH = 48
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [ehtu_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  wire logic [ehtu_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [ehtu_pkg::SAMPLE_W-1:0]     s_sample,
    input  wire logic                              s_block_end,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic                                   m_rep_fail,
    output logic                                   m_prop_fail,
    output logic                                   m_block_fail,
    output logic                                   m_block_last,
    output logic [ehtu_pkg::OUT_COUNT_W-1:0]       m_total_count,
    output logic [ehtu_pkg::OUT_COUNT_W-1:0]       m_failed_count,
    output logic [ehtu_pkg::OUT_COUNT_W-1:0]       m_rep_fail_count,
    output logic [ehtu_pkg::OUT_COUNT_W-1:0]       m_prop_fail_count
);
    import ehtu_pkg::*;

    logic [REP_CUT_W-1:0]   run_limit_reg;
    logic [PROP_CUT_W-1:0]  prop_cutoff_reg;
    logic [WIN_SIZE_W-1:0]  window_size_reg;

    logic                   in_valid_reg;
    logic [SAMPLE_W-1:0]    in_sample_reg;
    logic                   in_block_end_reg;

    logic                   out_valid_reg;
    logic                   out_rep_fail_reg;
    logic                   out_prop_fail_reg;
    logic                   out_block_fail_reg;
    logic                   out_block_last_reg;
    logic [OUT_COUNT_W-1:0] out_total_reg;
    logic [OUT_COUNT_W-1:0] out_failed_reg;
    logic [OUT_COUNT_W-1:0] out_rep_reg;
    logic [OUT_COUNT_W-1:0] out_prop_reg;

    logic                   block_failed_reg;
    logic                   block_fail_now;
    logic                   advance;
    flags_t                 flags;
    logic [OUT_COUNT_W-1:0] total_next;
    logic [OUT_COUNT_W-1:0] failed_next;
    logic [OUT_COUNT_W-1:0] rep_next;
    logic [OUT_COUNT_W-1:0] prop_next;

    // Move a sample into the result register when the result slot frees up
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // Configuration register decode
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_limit_reg   <= RUN_LIMIT_RST;
            prop_cutoff_reg <= PROP_CUTOFF_RST;
            window_size_reg <= WINDOW_SIZE_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_RUN_LIMIT:   run_limit_reg   <= cfg_wdata[REP_CUT_W-1:0];
                REG_PROP_CUTOFF: prop_cutoff_reg <= cfg_wdata[PROP_CUT_W-1:0];
                REG_WINDOW_SIZE: window_size_reg <= cfg_wdata[WIN_SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register: hold the accepted transaction until it advances
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_sample_reg    <= s_sample;
            in_block_end_reg <= s_block_end;
        end
    end

    // Test units
    ehtu_rep_test u_rep (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (advance),
        .sample     (in_sample_reg),
        .run_limit  (run_limit_reg),
        .rep_fail   (flags.rep_fail)
    );

    ehtu_prop_test #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_prop (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (advance),
        .sample      (in_sample_reg),
        .prop_cutoff (prop_cutoff_reg),
        .window_size (window_size_reg),
        .prop_fail   (flags.prop_fail)
    );

    ehtu_stat_counters #(
        .STAT_WIDTH (STAT_WIDTH)
    ) u_stats (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (advance),
        .flags       (flags),
        .total_next  (total_next),
        .failed_next (failed_next),
        .rep_next    (rep_next),
        .prop_next   (prop_next)
    );

    // Sticky block failure, cleared after the block's last sample
    assign block_fail_now = block_failed_reg || flags.rep_fail || flags.prop_fail;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_failed_reg <= 1'b0;
        end else if (advance) begin
            block_failed_reg <= in_block_end_reg ? 1'b0 : block_fail_now;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_rep_fail_reg   <= flags.rep_fail;
            out_prop_fail_reg  <= flags.prop_fail;
            out_block_fail_reg <= block_fail_now;
            out_block_last_reg <= in_block_end_reg;
            out_total_reg      <= total_next;
            out_failed_reg     <= failed_next;
            out_rep_reg        <= rep_next;
            out_prop_reg       <= prop_next;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_rep_fail        = out_rep_fail_reg;
    assign m_prop_fail       = out_prop_fail_reg;
    assign m_block_fail      = out_block_fail_reg;
    assign m_block_last      = out_block_last_reg;
    assign m_total_count     = out_total_reg;
    assign m_failed_count    = out_failed_reg;
    assign m_rep_fail_count  = out_rep_reg;
    assign m_prop_fail_count = out_prop_reg;

    `ASSERT_IMPLIES(a_blk_fail, aclk, aresetn, m_valid && (m_rep_fail || m_prop_fail), m_block_fail)
    `ASSERT_NEXT(a_stalled_sample_held, aclk, aresetn, in_valid_reg && !advance, in_valid_reg)

endmodule

`default_nettype wire

// ----- rtl/ehtu_rep_test.sv -----
// Repetition count test: run length tracking of equal samples.
`default_nettype none

module ehtu_rep_test (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           step,
    input  wire logic [ehtu_pkg::SAMPLE_W-1:0]  sample,
    input  wire logic [ehtu_pkg::REP_CUT_W-1:0] run_limit,
    output logic                                rep_fail
);
    import ehtu_pkg::*;

    logic [SAMPLE_W-1:0] last_value_reg;
    logic [SAMPLE_W-1:0] run_length_reg;
    logic [SAMPLE_W-1:0] run_length_next;
    logic [SAMPLE_W-1:0] run_inc;
    logic                same;

    // Extend or restart the run
    always_comb begin
        same     = (sample == last_value_reg);
        run_inc  = (run_length_reg == RUN_MAX) ? run_length_reg : run_length_reg + 8'd1;
        run_length_next = same ? run_inc : 8'd1;
        rep_fail = same && (run_inc >= run_limit);
    end

    // Advance state on each processed sample
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_value_reg <= '0;
            run_length_reg <= '0;
        end else if (step) begin
            last_value_reg <= sample;
            run_length_reg <= run_length_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/ehtu_prop_test.sv -----
// Adaptive proportion test: base sample match counting over a window.
`default_nettype none
`include "assert_macros.svh"

module ehtu_prop_test #(
    parameter int MAX_WINDOW = 4096
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            step,
    input  wire logic [ehtu_pkg::SAMPLE_W-1:0]   sample,
    input  wire logic [ehtu_pkg::PROP_CUT_W-1:0] prop_cutoff,
    input  wire logic [ehtu_pkg::WIN_SIZE_W-1:0] window_size,
    output logic                                 prop_fail
);
    import ehtu_pkg::*;

    localparam int PW = $clog2(MAX_WINDOW + 1);
    localparam int CW = (PW > WIN_SIZE_W) ? PW : WIN_SIZE_W;

    logic [SAMPLE_W-1:0] base_value_reg;
    logic [SAMPLE_W-1:0] base_value_next;
    logic [PW-1:0]       matches_reg;
    logic [PW-1:0]       matches_next;
    logic [PW-1:0]       match_inc;
    logic [PW-1:0]       pos_reg;
    logic [PW-1:0]       pos_next;
    logic [PW-1:0]       pos_inc;
    logic [CW-1:0]       win;
    logic                opening;
    logic                hit;

    // Clamp window, count matches, decide window restart
    always_comb begin
        win = (CW'(window_size) > CW'(MAX_WINDOW)) ? CW'(MAX_WINDOW) : CW'(window_size);
        opening   = (pos_reg == '0);
        pos_inc   = pos_reg + 1'b1;
        match_inc = matches_reg + PW'(sample == base_value_reg);
        hit       = (CW'(match_inc) >= CW'(prop_cutoff));
        prop_fail = !opening && hit;
        if (opening) begin
            base_value_next = sample;
            matches_next    = PW'(1);
            pos_next        = PW'(1);
        end else begin
            base_value_next = base_value_reg;
            matches_next    = match_inc;
            if (hit || (CW'(pos_inc) >= win)) begin
                pos_next = '0;
            end else begin
                pos_next = pos_inc;
            end
        end
    end

    // Advance state on each processed sample
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_value_reg <= '0;
            matches_reg    <= '0;
            pos_reg        <= '0;
        end else if (step) begin
            base_value_reg <= base_value_next;
            matches_reg    <= matches_next;
            pos_reg        <= pos_next;
        end
    end

    `ASSERT_IMPLIES(a_matches_in_window, aclk, aresetn, pos_reg != '0, matches_reg <= pos_reg)

endmodule

`default_nettype wire

// ----- rtl/ehtu_stat_counters.sv -----
// Saturating statistics counters for samples and test failures.
`default_nettype none
`include "assert_macros.svh"

module ehtu_stat_counters #(
    parameter int STAT_WIDTH = 48
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              step,
    input  wire ehtu_pkg::flags_t                  flags,
    output logic [ehtu_pkg::OUT_COUNT_W-1:0]       total_next,
    output logic [ehtu_pkg::OUT_COUNT_W-1:0]       failed_next,
    output logic [ehtu_pkg::OUT_COUNT_W-1:0]       rep_next,
    output logic [ehtu_pkg::OUT_COUNT_W-1:0]       prop_next
);
    import ehtu_pkg::*;

    localparam int EW = (STAT_WIDTH > OUT_COUNT_W) ? STAT_WIDTH : OUT_COUNT_W;

    logic [STAT_WIDTH-1:0] total_reg;
    logic [STAT_WIDTH-1:0] failed_reg;
    logic [STAT_WIDTH-1:0] rep_reg;
    logic [STAT_WIDTH-1:0] prop_reg;
    logic [STAT_WIDTH-1:0] total_cnt_next;
    logic [STAT_WIDTH-1:0] failed_cnt_next;
    logic [STAT_WIDTH-1:0] rep_cnt_next;
    logic [STAT_WIDTH-1:0] prop_cnt_next;
    logic [EW-1:0]         total_ext;
    logic [EW-1:0]         failed_ext;
    logic [EW-1:0]         rep_ext;
    logic [EW-1:0]         prop_ext;

    // Add 0..2 and stick at all ones on carry out
    function automatic logic [STAT_WIDTH-1:0] sat_add(
        input logic [STAT_WIDTH-1:0] v,
        input logic [1:0]            inc
    );
        logic [STAT_WIDTH:0] sum;
        sum = {1'b0, v} + (STAT_WIDTH + 1)'(inc);
        return sum[STAT_WIDTH] ? {STAT_WIDTH{1'b1}} : sum[STAT_WIDTH-1:0];
    endfunction

    // Compute post-update counts
    always_comb begin
        total_cnt_next  = sat_add(total_reg, 2'd1);
        rep_cnt_next    = sat_add(rep_reg, {1'b0, flags.rep_fail});
        prop_cnt_next   = sat_add(prop_reg, {1'b0, flags.prop_fail});
        failed_cnt_next = sat_add(failed_reg,
                                  2'({1'b0, flags.rep_fail} + {1'b0, flags.prop_fail}));
        total_ext  = EW'(total_cnt_next);
        failed_ext = EW'(failed_cnt_next);
        rep_ext    = EW'(rep_cnt_next);
        prop_ext   = EW'(prop_cnt_next);
        total_next  = total_ext[OUT_COUNT_W-1:0];
        failed_next = failed_ext[OUT_COUNT_W-1:0];
        rep_next    = rep_ext[OUT_COUNT_W-1:0];
        prop_next   = prop_ext[OUT_COUNT_W-1:0];
    end

    // Commit counts on each processed sample
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg  <= '0;
            failed_reg <= '0;
            rep_reg    <= '0;
            prop_reg   <= '0;
        end else if (step) begin
            total_reg  <= total_cnt_next;
            failed_reg <= failed_cnt_next;
            rep_reg    <= rep_cnt_next;
            prop_reg   <= prop_cnt_next;
        end
    end

    `ASSERT_IMPLIES(a_failed_covers_rep, aclk, aresetn, 1'b1, failed_reg >= rep_reg)
    `ASSERT_IMPLIES(a_failed_covers_prop, aclk, aresetn, 1'b1, failed_reg >= prop_reg)

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// Testbench for entropy_health_tests_unit: directed and random samples checked against a predictor.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ehtu_pkg::*;

    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;
    localparam logic [WIN_SIZE_W-1:0] WINDOW_CAP = 13'd4096;
    localparam logic [OUT_COUNT_W-1:0] STAT_MAX = {OUT_COUNT_W{1'b1}};
    localparam int SETTLE_CYCLES = 4;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic                   rep_fail;
        logic                   prop_fail;
        logic                   block_fail;
        logic                   block_last;
        logic [OUT_COUNT_W-1:0] total_count;
        logic [OUT_COUNT_W-1:0] failed_count;
        logic [OUT_COUNT_W-1:0] rep_fail_count;
        logic [OUT_COUNT_W-1:0] prop_fail_count;
    } health_result_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic [CFG_ADDR_W-1:0]  cfg_addr;
    logic [CFG_DATA_W-1:0]  cfg_wdata;
    logic                   s_valid;
    logic                   s_ready;
    logic [SAMPLE_W-1:0]    s_sample;
    logic                   s_block_end;
    logic                   m_valid;
    logic                   m_ready;
    logic                   m_rep_fail;
    logic                   m_prop_fail;
    logic                   m_block_fail;
    logic                   m_block_last;
    logic [OUT_COUNT_W-1:0] m_total_count;
    logic [OUT_COUNT_W-1:0] m_failed_count;
    logic [OUT_COUNT_W-1:0] m_rep_fail_count;
    logic [OUT_COUNT_W-1:0] m_prop_fail_count;

    entropy_health_tests_unit DUT (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_addr          (cfg_addr),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_sample          (s_sample),
        .s_block_end       (s_block_end),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_rep_fail        (m_rep_fail),
        .m_prop_fail       (m_prop_fail),
        .m_block_fail      (m_block_fail),
        .m_block_last      (m_block_last),
        .m_total_count     (m_total_count),
        .m_failed_count    (m_failed_count),
        .m_rep_fail_count  (m_rep_fail_count),
        .m_prop_fail_count (m_prop_fail_count)
    );

    // Predicted results, oldest first
    health_result_t expected_results[$];
    int mismatches = 0;

    // Predictor copy of configuration
    logic [REP_CUT_W-1:0]  cut_rep;
    logic [PROP_CUT_W-1:0] cut_prop;
    logic [WIN_SIZE_W-1:0] win_size;

    // Predictor copy of test state
    logic [SAMPLE_W-1:0]    prev_sample;
    logic [SAMPLE_W-1:0]    run_len;
    logic [SAMPLE_W-1:0]    base_sample;
    logic [PROP_CUT_W-1:0]  base_hits;
    logic [WIN_SIZE_W-1:0]  win_pos;
    logic                   blk_failed;
    logic [OUT_COUNT_W-1:0] cnt_total;
    logic [OUT_COUNT_W-1:0] cnt_failed;
    logic [OUT_COUNT_W-1:0] cnt_rep;
    logic [OUT_COUNT_W-1:0] cnt_prop;

    // Sender and receiver pacing
    int  burst_left;
    bit  gaps_on;
    int  hold_req;
    int  hold_len;

    // Clock
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Run limit
    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic logic [OUT_COUNT_W-1:0] stat_bump(input logic [OUT_COUNT_W-1:0] v);
        return (v >= STAT_MAX) ? STAT_MAX : v + 1'b1;
    endfunction

    function automatic void clear_health_state();
        cut_rep     = RUN_LIMIT_RST;
        cut_prop    = PROP_CUTOFF_RST;
        win_size    = WINDOW_SIZE_RST;
        prev_sample = '0;
        run_len     = '0;
        base_sample = '0;
        base_hits   = '0;
        win_pos     = '0;
        blk_failed  = 1'b0;
        cnt_total   = '0;
        cnt_failed  = '0;
        cnt_rep     = '0;
        cnt_prop    = '0;
    endfunction

    // Advance the predicted test state by one sample and queue its result
    function automatic void predict_health(input logic [SAMPLE_W-1:0] smp, input logic be);
        health_result_t r;
        logic rf;
        logic pf;
        logic [WIN_SIZE_W-1:0] win;
        win = (win_size > WINDOW_CAP) ? WINDOW_CAP : win_size;
        cnt_total = stat_bump(cnt_total);

        // repetition count
        if (smp == prev_sample) begin
            if (run_len < RUN_MAX)
                run_len = run_len + 1'b1;
            rf = (run_len >= cut_rep);
        end else begin
            prev_sample = smp;
            run_len = 8'd1;
            rf = 1'b0;
        end
        if (rf) begin
            cnt_rep    = stat_bump(cnt_rep);
            cnt_failed = stat_bump(cnt_failed);
        end

        // adaptive proportion
        pf = 1'b0;
        if (win_pos == 0) begin
            base_sample = smp;
            base_hits   = 13'd1;
            win_pos     = 13'd1;
        end else begin
            win_pos = win_pos + 1'b1;
            if (smp == base_sample)
                base_hits = base_hits + 1'b1;
            if (base_hits >= cut_prop) begin
                win_pos = '0;
                pf = 1'b1;
            end else if (win_pos >= win) begin
                win_pos = '0;
            end
        end
        if (pf) begin
            cnt_prop   = stat_bump(cnt_prop);
            cnt_failed = stat_bump(cnt_failed);
        end

        if (rf || pf)
            blk_failed = 1'b1;
        r.rep_fail        = rf;
        r.prop_fail       = pf;
        r.block_fail      = blk_failed;
        r.block_last      = be;
        r.total_count     = cnt_total;
        r.failed_count    = cnt_failed;
        r.rep_fail_count  = cnt_rep;
        r.prop_fail_count = cnt_prop;
        if (be)
            blk_failed = 1'b0;
        expected_results.push_back(r);
    endfunction

    // Offer one sample, pacing the sender in bursts, and wait for its transaction
    task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input logic be);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 32);
            gap = gaps_on ? $urandom_range(0, 6) : 0;
            if (gap != 0) begin
                @(negedge aclk);
                s_valid = 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        burst_left--;
        @(negedge aclk);
        s_valid     = 1'b1;
        s_sample    = smp;
        s_block_end = be;
        forever begin
            @(posedge aclk);
            if (s_ready)
                break;
        end
        predict_health(smp, be);
    endtask

    // Drop valid and hold until every predicted result has arrived
    task automatic wait_drained();
        @(negedge aclk);
        s_valid = 1'b0;
        while (expected_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = data;
        @(posedge aclk);
        case (idx)
            REG_RUN_LIMIT:   cut_rep  = data[REP_CUT_W-1:0];
            REG_PROP_CUTOFF: cut_prop = data[PROP_CUT_W-1:0];
            REG_WINDOW_SIZE: win_size = data[WIN_SIZE_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic set_config(input int rep, input int prop, input int win);
        write_reg(REG_RUN_LIMIT, CFG_DATA_W'(rep));
        write_reg(REG_PROP_CUTOFF, CFG_DATA_W'(prop));
        write_reg(REG_WINDOW_SIZE, CFG_DATA_W'(win));
    endtask

    // Reset values: runs of zero from reset, extremes, block ends
    task automatic test_reset_defaults();
        int k;
        for (k = 0; k < 7; k++)
            send_sample(8'h00, 1'b0);
        send_sample(8'hFF, 1'b0);
        send_sample(8'hFF, 1'b1);
        send_sample(8'h80, 1'b0);
        send_sample(8'h7F, 1'b1);
        wait_drained();
    endtask

    // Cutoffs and windows of zero and one, register masking, unused index
    task automatic test_tiny_settings();
        write_reg(REG_RUN_LIMIT, 13'h1F00);
        write_reg(REG_PROP_CUTOFF, 13'h0000);
        write_reg(REG_WINDOW_SIZE, 13'h0000);
        send_sample(8'h11, 1'b0);
        send_sample(8'h11, 1'b0);
        send_sample(8'h22, 1'b0);
        send_sample(8'h33, 1'b0);
        send_sample(8'h33, 1'b1);
        wait_drained();
        set_config(13'h1E01, 1, 1);
        send_sample(8'h44, 1'b0);
        send_sample(8'h44, 1'b0);
        send_sample(8'h55, 1'b0);
        send_sample(8'h55, 1'b0);
        send_sample(8'h55, 1'b1);
        wait_drained();
        write_reg(REG_UNUSED, 13'h1FFF);
        send_sample(8'h55, 1'b0);
        send_sample(8'hAA, 1'b1);
        wait_drained();
    endtask

    // Run length saturates at its maximum and keeps failing
    task automatic test_run_saturation();
        int k;
        set_config(255, 8191, 64);
        for (k = 0; k < 300; k++)
            send_sample(8'hC3, (k % 100) == 99);
        wait_drained();
        set_config(200, 8191, 64);
        for (k = 0; k < 20; k++)
            send_sample(8'hC3, k == 19);
        wait_drained();
    endtask

    // A window size beyond the cap keeps one window open over a long stretch
    task automatic test_window_cap();
        int k;
        logic [SAMPLE_W-1:0] smp;
        set_config(255, 2, 13'h1FFF);
        send_sample(8'hA5, 1'b0);
        for (k = 0; k < 300; k++) begin
            smp = SAMPLE_W'($urandom_range(0, 254));
            if (smp >= 8'hA5)
                smp = smp + 1'b1;
            send_sample(smp, 1'b0);
        end
        send_sample(8'h3C, 1'b0);
        send_sample(8'h3C, 1'b1);
        wait_drained();
        set_config(6, 4096, 4096);
        for (k = 0; k < 8; k++)
            send_sample(8'h01, 1'b0);
        wait_drained();
    endtask

    // Hold the receiver off so the block fills, then pause the sender until drained
    task automatic test_backpressure();
        int k;
        set_config(3, 5, 16);
        gaps_on  = 1'b0;
        hold_len = 300;
        hold_req++;
        for (k = 0; k < 48; k++)
            send_sample(SAMPLE_W'($urandom_range(0, 3)), $urandom_range(0, 7) == 0);
        wait_drained();
        for (k = 0; k < 16; k++)
            send_sample(SAMPLE_W'($urandom_range(0, 3)), $urandom_range(0, 7) == 0);
        wait_drained();
        gaps_on = 1'b1;
    endtask

    // Random configurations with sample streams shaped to build runs and matches
    task automatic test_random_streams();
        int phase;
        int k;
        int rep;
        int prop;
        int win;
        int repeat_pct;
        logic [SAMPLE_W-1:0] mask;
        logic [SAMPLE_W-1:0] ofs;
        logic [SAMPLE_W-1:0] smp;
        for (phase = 0; phase < 8; phase++) begin
            case ($urandom_range(0, 9))
                0: rep = $urandom_range(0, 1);
                1: rep = 255;
                default: rep = $urandom_range(2, 12);
            endcase
            case ($urandom_range(0, 9))
                0: win = $urandom_range(0, 1);
                1: win = $urandom_range(4097, 8191);
                2: win = 4096;
                default: win = $urandom_range(2, 64);
            endcase
            case ($urandom_range(0, 9))
                0: prop = $urandom_range(0, 1);
                1: prop = 8191;
                default: prop = $urandom_range(2, 24);
            endcase
            set_config(rep, prop, win);
            case ($urandom_range(0, 4))
                0: mask = 8'h00;
                1: mask = 8'h01;
                2: mask = 8'h03;
                3: mask = 8'h0F;
                default: mask = 8'hFF;
            endcase
            ofs = SAMPLE_W'($urandom_range(0, 255));
            repeat_pct = (mask == 8'hFF) ? $urandom_range(0, 20) : $urandom_range(0, 80);
            gaps_on = ($urandom_range(0, 3) != 0);
            smp = ofs;
            for (k = 0; k < 154; k++) begin
                if ($urandom_range(0, 99) >= repeat_pct)
                    smp = ofs ^ (SAMPLE_W'($urandom) & mask);
                send_sample(smp, $urandom_range(0, 11) == 0);
            end
            wait_drained();
        end
        gaps_on = 1'b1;
    endtask

    // Receiver readiness: random segments of stall density, plus requested hold-offs
    initial begin : receiver_pattern
        int seg_left;
        int stall_pct;
        int hold_seen;
        seg_left  = 0;
        stall_pct = 0;
        hold_seen = 0;
        m_ready   = 1'b1;
        forever begin
            @(negedge aclk);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                m_ready = 1'b0;
                repeat (hold_len - 1) @(negedge aclk);
            end else begin
                if (seg_left == 0) begin
                    seg_left = $urandom_range(16, 128);
                    case ($urandom_range(0, 4))
                        0, 1: stall_pct = 0;
                        2: stall_pct = 25;
                        3: stall_pct = 60;
                        default: stall_pct = 90;
                    endcase
                end
                seg_left--;
                m_ready = ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // Compare each result transaction with the oldest prediction
    always @(posedge aclk) begin : result_check
        health_result_t want;
        health_result_t got;
        if (aresetn && m_valid && m_ready) begin
            got.rep_fail        = m_rep_fail;
            got.prop_fail       = m_prop_fail;
            got.block_fail      = m_block_fail;
            got.block_last      = m_block_last;
            got.total_count     = m_total_count;
            got.failed_count    = m_failed_count;
            got.rep_fail_count  = m_rep_fail_count;
            got.prop_fail_count = m_prop_fail_count;
            if (expected_results.size() == 0) begin
                if (mismatches < REPORT_LIMIT)
                    $display("%0t: result with no sample pending", $realtime);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                if (got.rep_fail !== want.rep_fail || got.prop_fail !== want.prop_fail ||
                    got.block_fail !== want.block_fail || got.block_last !== want.block_last ||
                    got.total_count !== want.total_count ||
                    got.failed_count !== want.failed_count ||
                    got.rep_fail_count !== want.rep_fail_count ||
                    got.prop_fail_count !== want.prop_fail_count) begin
                    if (mismatches < REPORT_LIMIT) begin
                        $display("%0t: mismatch rep/prop/blk/last exp %b%b%b%b got %b%b%b%b",
                                 $realtime, want.rep_fail, want.prop_fail, want.block_fail,
                                 want.block_last, got.rep_fail, got.prop_fail,
                                 got.block_fail, got.block_last);
                        $display("    counts exp %0d %0d %0d %0d got %0d %0d %0d %0d",
                                 want.total_count, want.failed_count, want.rep_fail_count,
                                 want.prop_fail_count, got.total_count, got.failed_count,
                                 got.rep_fail_count, got.prop_fail_count);
                    end
                    mismatches++;
                end
            end
        end
    end

    // Main sequence
    initial begin
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_addr    = '0;
        cfg_wdata   = '0;
        s_valid     = 1'b0;
        s_sample    = '0;
        s_block_end = 1'b0;
        burst_left  = 0;
        gaps_on     = 1'b1;
        hold_req    = 0;
        hold_len    = 0;
        clear_health_state();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_reset_defaults();
        test_tiny_settings();
        test_run_saturation();
        test_window_cap();
        test_backpressure();
        test_random_streams();

        wait_drained();
        repeat (8) @(posedge aclk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire

// ----- filelist.f -----
+incdir+rtl
rtl/ehtu_pkg.sv
rtl/ehtu_rep_test.sv
rtl/ehtu_prop_test.sv
rtl/ehtu_stat_counters.sv
rtl/entropy_health_tests_unit.sv
tb/tb.sv
